// ===== design/tdp_pkg.sv =====
// Shared types and constants for the trial-division prime test.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package tdp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam int SMALL_PRIME_MAX = 3;
  localparam int ODD_DIVISOR     = 3;
  localparam int FIRST_DIVISOR   = 5;
  localparam int PAIR_OFFSET     = 2;
  localparam int DIVISOR_STEP    = 6;

  typedef enum logic [1:0] {
    SEL_THREE = 2'd0,
    SEL_LOW   = 2'd1,
    SEL_HIGH  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     d_init;
    logic     d_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_le_one;
    logic n_le_three;
    logic n_even;
    logic div_done;
    logic rem_zero;
    logic d_gt_quo;
  } dp_status_t;

endpackage

// ===== design/trial_division_prime_test.sv =====
// Top level of the trial-division prime test: controller plus datapath.
// Depends on tdp_pkg, tdp_controller and tdp_datapath.
`timescale 1ns / 1ps

// One candidate is taken per beat when start is high and busy is low, and
// exactly one flag comes back on out_is_prime with out_strobe high for a
// single cycle; the receiver cannot stall, so it must take the beat then.
// Candidates that are negative, at most 3, or even are answered from the
// classify state without a division. Every other candidate runs through one
// shared restoring divider: one division by 3, then up to two per trial pair
// 6k-1, 6k+1 until the divisor exceeds the quotient. Busy stays high until
// the cycle in which the result strobe appears.
module trial_division_prime_test #(
  parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_candidate,
  output logic                          out_strobe,
  output logic                          out_is_prime
);

  tdp_pkg::ctrl_cmd_t  cmd;
  tdp_pkg::dp_status_t status;

  tdp_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .out_strobe   (out_strobe),
    .out_is_prime (out_is_prime),
    .cmd          (cmd),
    .status       (status)
  );

  tdp_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .candidate (in_candidate),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== design/tdp_datapath.sv =====
// Datapath of the prime test: candidate and trial divisor registers and a
// restoring divider that produces one quotient bit per cycle.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_datapath #(
  parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_WIDTH-1:0] candidate,
  input  tdp_pkg::ctrl_cmd_t            cmd,
  output tdp_pkg::dp_status_t           status
);

  localparam int U  = VALUE_WIDTH - 1;
  localparam int CW = $clog2(U);

  logic          neg_r;
  logic [U-1:0]  n_r;
  logic [U-1:0]  d_r;
  logic [U-1:0]  dv_r;
  logic [U-1:0]  rem_r;
  logic [U-1:0]  quo_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [U:0]    rem_sh;
  logic [U:0]    diff;
  logic          ge;
  logic [U-1:0]  dv_nxt;

  assign rem_sh = {rem_r, quo_r[U-1]};
  assign ge     = rem_sh >= {1'b0, dv_r};
  assign diff   = rem_sh - {1'b0, dv_r};

  always_comb begin
    case (cmd.div_sel)
      tdp_pkg::SEL_THREE: dv_nxt = U'(tdp_pkg::ODD_DIVISOR);
      tdp_pkg::SEL_LOW:   dv_nxt = d_r;
      tdp_pkg::SEL_HIGH:  dv_nxt = d_r + U'(tdp_pkg::PAIR_OFFSET);
      default:            dv_nxt = d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.div_start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == '0)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= candidate[VALUE_WIDTH-1];
      n_r   <= candidate[U-1:0];
    end
    if (cmd.d_init) begin
      d_r <= U'(tdp_pkg::FIRST_DIVISOR);
    end else if (cmd.d_step) begin
      d_r <= d_r + U'(tdp_pkg::DIVISOR_STEP);
    end
    if (cmd.div_start) begin
      dv_r  <= dv_nxt;
      rem_r <= '0;
      quo_r <= n_r;
      cnt_r <= CW'(U - 1);
    end else if (run_r) begin
      rem_r <= ge ? diff[U-1:0] : rem_sh[U-1:0];
      quo_r <= {quo_r[U-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign status.n_le_one   = neg_r || (n_r <= U'(1));
  assign status.n_le_three = n_r <= U'(tdp_pkg::SMALL_PRIME_MAX);
  assign status.n_even     = !n_r[0];
  assign status.div_done   = done_r;
  assign status.rem_zero   = rem_r == '0;
  assign status.d_gt_quo   = d_r > quo_r;

endmodule

// ===== design/tdp_controller.sv =====
// Controller of the prime test: sequences the screening checks and the
// trial divisions, and drives the result strobe. Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_strobe,
  output logic                out_is_prime,
  output tdp_pkg::ctrl_cmd_t  cmd,
  input  tdp_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_WAIT_THREE,
    ST_START_LOW,
    ST_WAIT_LOW,
    ST_WAIT_HIGH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   strobe_nxt;
  logic   prime_nxt;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    prime_nxt  = 1'b0;
    cmd        = '{load: 1'b0, div_start: 1'b0, div_sel: tdp_pkg::SEL_THREE,
                   d_init: 1'b0, d_step: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (status.n_le_one || status.n_even && !status.n_le_three) begin
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (status.n_le_three) begin
          strobe_nxt = 1'b1;
          prime_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tdp_pkg::SEL_THREE;
          state_nxt     = ST_WAIT_THREE;
        end
      end
      ST_WAIT_THREE: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            strobe_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.d_init = 1'b1;
            state_nxt  = ST_START_LOW;
          end
        end
      end
      ST_START_LOW: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tdp_pkg::SEL_LOW;
        state_nxt     = ST_WAIT_LOW;
      end
      ST_WAIT_LOW: begin
        if (status.div_done) begin
          if (status.d_gt_quo) begin
            strobe_nxt = 1'b1;
            prime_nxt  = 1'b1;
            state_nxt  = ST_IDLE;
          end else if (status.rem_zero) begin
            strobe_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = tdp_pkg::SEL_HIGH;
            state_nxt     = ST_WAIT_HIGH;
          end
        end
      end
      ST_WAIT_HIGH: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            strobe_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.d_step = 1'b1;
            state_nxt  = ST_START_LOW;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe   <= 1'b0;
      out_is_prime <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe   <= strobe_nxt;
      out_is_prime <= prime_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

endmodule

// ===== design/tdp_checker.sv =====
// Port-level checker for the trial-division prime test, bound to the top.
// Depends on tdp_pkg and trial_division_prime_test.
`timescale 1ns / 1ps

module tdp_checker #(
  parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic signed [VALUE_WIDTH-1:0] in_candidate,
  input logic                          out_strobe,
  input logic                          out_is_prime
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted beat");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe lasted more than one cycle");

  a_busy_fall_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result beat");

  a_negative: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_candidate[VALUE_WIDTH-1] |-> ##2 (out_strobe && !out_is_prime))
    else $error("negative candidate not rejected on time");

  a_small_prime: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_candidate == VALUE_WIDTH'(2) || in_candidate == VALUE_WIDTH'(3))
    |-> ##2 (out_strobe && out_is_prime))
    else $error("2 or 3 not reported prime on time");

endmodule

bind trial_division_prime_test tdp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_tdp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_candidate (in_candidate),
  .out_strobe   (out_strobe),
  .out_is_prime (out_is_prime)
);

// ===== tb/trial_division_prime_test_tb.sv =====
// Self-checking testbench for trial_division_prime_test: directed rows, then
// random candidates under three sender gap settings, checked against a local predictor.
// Depends on tdp_pkg and the trial_division_prime_test RTL.
`timescale 1ns / 1ps

module trial_division_prime_test_tb;

  localparam int VW           = tdp_pkg::VALUE_WIDTH_DEF;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int END_PAUSE    = 16;
  localparam int RAND_PER_PH  = 26;
  localparam int NUM_ROWS     = 23;

  typedef struct packed {
    logic signed [VW-1:0] cand;
    logic                 typed;
    logic                 flag;
  } row_t;

  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    '{-32'sd2147483648, 1'b1, 1'b0},
    '{-32'sd1,          1'b1, 1'b0},
    '{32'sd0,           1'b1, 1'b0},
    '{32'sd1,           1'b1, 1'b0},
    '{32'sd2,           1'b1, 1'b1},
    '{32'sd3,           1'b1, 1'b1},
    '{32'sd4,           1'b1, 1'b0},
    '{32'sd6,           1'b1, 1'b0},
    '{32'sd9,           1'b1, 1'b0},
    '{32'sd5,           1'b1, 1'b1},
    '{32'sd7,           1'b1, 1'b1},
    '{32'sd25,          1'b0, 1'b0},
    '{32'sd35,          1'b0, 1'b0},
    '{32'sd49,          1'b0, 1'b0},
    '{32'sd121,         1'b0, 1'b0},
    '{32'sd97,          1'b0, 1'b0},
    '{32'sd65521,       1'b0, 1'b0},
    '{32'sd1000003,     1'b0, 1'b0},
    '{32'sd1073741823,  1'b0, 1'b0},
    '{32'sd2147483646,  1'b1, 1'b0},
    '{32'sd2147483645,  1'b0, 1'b0},
    '{32'sd2147483643,  1'b0, 1'b0},
    '{32'sd2147483647,  1'b1, 1'b1}
  };

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic signed [VW-1:0] in_candidate = '0;
  logic                 busy;
  logic                 out_strobe;
  logic                 out_is_prime;

  bit          expected_flags [$];
  int unsigned gap_pct;
  int unsigned cands_sent;
  int unsigned verdicts_seen;
  int unsigned primes_seen;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  trial_division_prime_test #(.VALUE_WIDTH(VW)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_candidate (in_candidate),
    .out_strobe   (out_strobe),
    .out_is_prime (out_is_prime)
  );

  always #10 clk = ~clk;

  function automatic bit prime_by_trial_division(input logic [VW-1:0] cand);
    longint unsigned n;
    longint unsigned d;
    bit              verdict;
    n = 64'(cand);
    if (cand[VW-1]) begin
      verdict = 1'b0;
    end else if (n <= 1) begin
      verdict = 1'b0;
    end else if (n <= 3) begin
      verdict = 1'b1;
    end else if ((n % 2) == 0 || (n % 3) == 0) begin
      verdict = 1'b0;
    end else begin
      verdict = 1'b1;
      for (d = 5; d * d <= n; d += 6) begin
        if ((n % d) == 0 || (n % (d + 2)) == 0) begin
          verdict = 1'b0;
          break;
        end
      end
    end
    return verdict;
  endfunction

  task automatic send_candidate(input logic signed [VW-1:0] cand, input bit typed,
                                input bit flag);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_candidate <= cand;
    do @(posedge clk); while (busy !== 1'b0);
    expected_flags.push_back(typed ? flag : prime_by_trial_division(cand));
    cands_sent++;
  endtask

  task automatic drain_verdicts();
    start <= 1'b0;
    @(posedge clk);
    while (expected_flags.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VW-1:0] random_candidate();
    int unsigned pick;
    logic [VW-1:0] v;
    pick = $urandom_range(99);
    if (pick < 45) begin
      v = $urandom_range(4095);
    end else if (pick < 65) begin
      v = $urandom_range(65535);
    end else if (pick < 80) begin
      v = ($urandom_range(250) + 2) * ($urandom_range(250) + 2);
    end else if (pick < 90) begin
      v = $urandom() | 32'h8000_0000;
    end else if (pick < 95) begin
      v = $urandom() & 32'h7fff_fffe;
    end else begin
      v = $urandom_range(715827882) * 3;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      verdicts_seen++;
      if (out_is_prime === 1'b1) primes_seen++;
      if (expected_flags.size() == 0) begin
        $error("is_prime: expected none, actual %0b", out_is_prime);
        mismatch_count++;
      end else begin
        bit exp_flag;
        exp_flag = expected_flags.pop_front();
        if (out_is_prime !== exp_flag) begin
          $error("is_prime: expected %0b, actual %0b", exp_flag, out_is_prime);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned phase_gaps [3];
    phase_gaps = '{31, 50, 0};
    gap_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_candidate(DIR_ROWS[i].cand, DIR_ROWS[i].typed, DIR_ROWS[i].flag);
    end
    drain_verdicts();

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = phase_gaps[ph];
      for (int i = 0; i < RAND_PER_PH; i++) begin
        send_candidate(random_candidate(), 1'b0, 1'b0);
      end
      drain_verdicts();
    end

    repeat (END_PAUSE) @(posedge clk);

    $display("Covered %0d candidates (%0d directed), %0d verdicts, %0d of them prime.",
             cands_sent, NUM_ROWS, verdicts_seen, primes_seen);
    $display("Random beats ran with sender gaps of 31, 50 and 0 percent.");
    if (mismatch_count == 0 && expected_flags.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== trial_division_prime_test.f =====
design/tdp_pkg.sv
design/tdp_datapath.sv
design/tdp_controller.sv
design/trial_division_prime_test.sv
design/tdp_checker.sv
tb/trial_division_prime_test_tb.sv
